[hw/rtl/tc_pkg.sv]
// ----------------------------------------------------------------------------
// tc_pkg: shared types and constants for the circumcenter block
// Output width, queue depth, parameter defaults and the flag group that
// travels from the front pipeline through the queue into the divider.
// ----------------------------------------------------------------------------
package tc_pkg;

  // Default input coordinate width and fractional bits of the result
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  // Width of each result coordinate
  localparam int OUT_BITS = 48;

  // Entries of the queue between front and back; covers the front latency
  localparam int QUEUE_DEPTH = 8;

  // Classification of one triangle
  typedef struct packed {
    logic collinear;
    logic neg_x;
    logic neg_y;
  } flags_t;

endpackage

[hw/rtl/tc_front.sv]
// ----------------------------------------------------------------------------
// tc_front: products and classification
// Four free-running stages: differences and sums, squared-norm differences
// and determinant, cross products, then numerator magnitudes and signs.
// ----------------------------------------------------------------------------
module tc_front #(
  parameter int COORD_BITS = tc_pkg::COORD_BITS_DEF,
  parameter int NW         = 3 * COORD_BITS + 5,
  parameter int DTW        = 2 * COORD_BITS + 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic signed [COORD_BITS-1:0] x0,
  input  logic signed [COORD_BITS-1:0] y0,
  input  logic signed [COORD_BITS-1:0] x1,
  input  logic signed [COORD_BITS-1:0] y1,
  input  logic signed [COORD_BITS-1:0] x2,
  input  logic signed [COORD_BITS-1:0] y2,
  output logic                         out_valid,
  output logic [NW-1:0]                mag_x,
  output logic [NW-1:0]                mag_y,
  output logic [DTW-1:0]               mag_det,
  output tc_pkg::flags_t               flags
);

  localparam int DW = COORD_BITS + 1;
  localparam int AW = 2 * COORD_BITS + 3;
  localparam int PW = 3 * COORD_BITS + 4;

  logic v1_r, v2_r, v3_r, v4_r;

  logic signed [DW-1:0] d01x_r, d01y_r, d02x_r, d02y_r;
  logic signed [DW-1:0] s01x_r, s01y_r, s02x_r, s02y_r;
  logic signed [DW-1:0] e01x_r, e01y_r, e02x_r, e02y_r;
  logic signed [AW-1:0] a_r, b_r, det2_r, det3_r;
  logic signed [AW-1:0] a_nxt, b_nxt, det_nxt;
  logic signed [PW-1:0] pa_r, pb_r, qa_r, qb_r;
  logic signed [NW-1:0] nx, ny;
  logic                 det_neg;
  logic [NW-1:0]        mag_x_r, mag_y_r;
  logic [DTW-1:0]       mag_det_r;
  tc_pkg::flags_t       flags_r;

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Squared-norm differences and determinant
  always_comb begin
    a_nxt   = AW'(d01x_r) * AW'(s01x_r) + AW'(d01y_r) * AW'(s01y_r);
    b_nxt   = AW'(d02x_r) * AW'(s02x_r) + AW'(d02y_r) * AW'(s02y_r);
    det_nxt = AW'(d01x_r) * AW'(d02y_r) - AW'(d02x_r) * AW'(d01y_r);
  end

  // Numerators; the y numerator carries the minus sign of its denominator
  always_comb begin
    nx      = NW'(pa_r) - NW'(pb_r);
    ny      = NW'(qb_r) - NW'(qa_r);
    det_neg = det3_r[AW-1];
  end

  // Data path stages
  always_ff @(posedge clk) begin
    d01x_r <= DW'(x0) - DW'(x1);
    d01y_r <= DW'(y0) - DW'(y1);
    d02x_r <= DW'(x0) - DW'(x2);
    d02y_r <= DW'(y0) - DW'(y2);
    s01x_r <= DW'(x0) + DW'(x1);
    s01y_r <= DW'(y0) + DW'(y1);
    s02x_r <= DW'(x0) + DW'(x2);
    s02y_r <= DW'(y0) + DW'(y2);

    a_r    <= a_nxt;
    b_r    <= b_nxt;
    det2_r <= det_nxt;
    e01x_r <= d01x_r;
    e01y_r <= d01y_r;
    e02x_r <= d02x_r;
    e02y_r <= d02y_r;

    pa_r   <= PW'(a_r) * PW'(e02y_r);
    pb_r   <= PW'(b_r) * PW'(e01y_r);
    qa_r   <= PW'(a_r) * PW'(e02x_r);
    qb_r   <= PW'(b_r) * PW'(e01x_r);
    det3_r <= det2_r;

    mag_x_r             <= nx[NW-1] ? NW'(-nx) : NW'(nx);
    mag_y_r             <= ny[NW-1] ? NW'(-ny) : NW'(ny);
    mag_det_r           <= det_neg ? DTW'(-det3_r) : DTW'(det3_r);
    flags_r.collinear   <= (det3_r == '0);
    flags_r.neg_x       <= nx[NW-1] ^ det_neg;
    flags_r.neg_y       <= ny[NW-1] ^ det_neg;
  end

  assign out_valid = v4_r;
  assign mag_x     = mag_x_r;
  assign mag_y     = mag_y_r;
  assign mag_det   = mag_det_r;
  assign flags     = flags_r;

endmodule

[hw/rtl/tc_fifo.sv]
// ----------------------------------------------------------------------------
// tc_fifo: short queue between the front pipeline and the divider
// Register array with read and write pointers; head is shown combinationally.
// ----------------------------------------------------------------------------
module tc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tc_pkg::QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic [WIDTH-1:0]         push_data,
  input  logic                     pop,
  output logic [WIDTH-1:0]         head,
  output logic                     empty,
  output logic [$clog2(DEPTH):0]   count
);

  localparam int PTRW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [PTRW-1:0]  wptr_r, rptr_r;
  logic [PTRW:0]    count_r;

  // Store a word
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= push_data;
    end
  end

  // Move pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + PTRW'(1);
      if (pop)  rptr_r <= rptr_r + PTRW'(1);
      count_r <= count_r + (PTRW+1)'(push) - (PTRW+1)'(pop);
    end
  end

  assign head  = mem[rptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

endmodule

[hw/rtl/tc_div.sv]
// ----------------------------------------------------------------------------
// tc_div: rounding divider pipeline and output register
// One restoring-division stage per quotient bit for x and y, sharing the
// divisor; then saturation and a result register. Stalls as a whole.
// ----------------------------------------------------------------------------
module tc_div #(
  parameter int COORD_BITS = tc_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = tc_pkg::FRAC_BITS_DEF,
  parameter int NW         = 3 * COORD_BITS + 5,
  parameter int DTW        = 2 * COORD_BITS + 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [NW-1:0]                mag_x,
  input  logic [NW-1:0]                mag_y,
  input  logic [DTW-1:0]               mag_det,
  input  tc_pkg::flags_t               flags,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tc_pkg::OUT_BITS-1:0]  center_x,
  output logic [tc_pkg::OUT_BITS-1:0]  center_y,
  output logic                         collinear,
  output logic                         overflow
);

  localparam int OUTW = tc_pkg::OUT_BITS;
  localparam int NUMW = NW + FRAC_BITS + 2;
  localparam int VW   = DTW + 2;
  localparam int EW   = (NUMW > OUTW) ? NUMW : OUTW + 1;

  // One restoring step: bring in the next dividend bit, subtract if it fits
  function automatic logic [VW+NUMW-1:0] div_step(
    input logic [VW-1:0]   rem,
    input logic [NUMW-1:0] dq,
    input logic [VW-1:0]   dvs
  );
    logic [VW:0] t;
    logic [VW:0] d;
    t = {rem, dq[NUMW-1]};
    d = t - {1'b0, dvs};
    if (t >= {1'b0, dvs}) begin
      return {d[VW-1:0], dq[NUMW-2:0], 1'b1};
    end else begin
      return {t[VW-1:0], dq[NUMW-2:0], 1'b0};
    end
  endfunction

  // Clamp a magnitude to the output range and apply the sign
  function automatic logic [OUTW:0] saturate(
    input logic [NUMW-1:0] q,
    input logic            neg
  );
    logic [EW-1:0]   qe;
    logic [EW-1:0]   lim;
    logic            ovf;
    logic [OUTW-1:0] val;
    qe  = EW'(q);
    lim = neg ? (EW'(1) << (OUTW - 1)) : ((EW'(1) << (OUTW - 1)) - EW'(1));
    ovf = (qe > lim);
    if (ovf) qe = lim;
    val = qe[OUTW-1:0];
    if (neg) val = -val;
    return {ovf, val};
  endfunction

  logic                v_r  [0:NUMW];
  logic [VW-1:0]       rx_r [0:NUMW];
  logic [VW-1:0]       ry_r [0:NUMW];
  logic [NUMW-1:0]     qx_r [0:NUMW];
  logic [NUMW-1:0]     qy_r [0:NUMW];
  logic [VW-1:0]       dv_r [0:NUMW];
  tc_pkg::flags_t      fl_r [0:NUMW];

  logic                adv;
  logic [NUMW-1:0]     bias;
  logic [OUTW:0]       sat_x, sat_y;
  logic                out_valid_r;
  logic [OUTW-1:0]     cx_r, cy_r;
  logic                col_r, ovf_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign bias     = NUMW'({mag_det, 1'b0});

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NUMW; k++) v_r[k] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
      for (int k = 1; k <= NUMW; k++) v_r[k] <= v_r[k-1];
    end
  end

  // Load: scale, add the rounding bias, form four times the determinant
  always_ff @(posedge clk) begin
    if (adv) begin
      rx_r[0] <= '0;
      ry_r[0] <= '0;
      qx_r[0] <= (NUMW'(mag_x) << (FRAC_BITS + 1)) + bias;
      qy_r[0] <= (NUMW'(mag_y) << (FRAC_BITS + 1)) + bias;
      dv_r[0] <= {mag_det, 2'b00};
      fl_r[0] <= flags;
    end
  end

  // Division stages, one quotient bit each
  for (genvar k = 1; k <= NUMW; k++) begin : g_step
    logic [VW+NUMW-1:0] sx, sy;
    always_comb begin
      sx = div_step(rx_r[k-1], qx_r[k-1], dv_r[k-1]);
      sy = div_step(ry_r[k-1], qy_r[k-1], dv_r[k-1]);
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        {rx_r[k], qx_r[k]} <= sx;
        {ry_r[k], qy_r[k]} <= sy;
        dv_r[k]            <= dv_r[k-1];
        fl_r[k]            <= fl_r[k-1];
      end
    end
  end

  always_comb begin
    sat_x = saturate(qx_r[NUMW], fl_r[NUMW].neg_x);
    sat_y = saturate(qy_r[NUMW], fl_r[NUMW].neg_y);
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_r[NUMW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      col_r <= fl_r[NUMW].collinear;
      if (fl_r[NUMW].collinear) begin
        cx_r  <= '0;
        cy_r  <= '0;
        ovf_r <= 1'b0;
      end else begin
        cx_r  <= sat_x[OUTW-1:0];
        cy_r  <= sat_y[OUTW-1:0];
        ovf_r <= sat_x[OUTW] | sat_y[OUTW];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign center_x  = cx_r;
  assign center_y  = cy_r;
  assign collinear = col_r;
  assign overflow  = ovf_r;

endmodule

[hw/rtl/triangle_circumcenter.sv]
// ----------------------------------------------------------------------------
// triangle_circumcenter: circumcenter of three points
// Takes one triangle per word on the in_ stream and returns its
// circumcenter on the out_ stream in signed fixed point with FRAC_BITS
// fractional bits, rounded to nearest (ties away from zero), saturated.
//
// Channels: in_tdata holds six COORD_BITS-bit signed coordinates; out_tdata
// holds center_x and center_y; out_tuser holds collinear and overflow.
// Collinear or repeated points give zero coordinates with collinear set.
// Throughput: one triangle per cycle while out_tready stays high. The divider
// spends one pipeline stage on each quotient bit.
// A four-stage front pipeline feeds a QUEUE_DEPTH-word queue; in_tready
// counts words inside the front and the queue, so the front never stalls.
// When out_tready is low the divider holds as a whole, the queue fills and
// in_tready drops; the word in the output register stays until taken.
// Reset empties the pipeline and the queue; no other state exists.
// ----------------------------------------------------------------------------
module triangle_circumcenter #(
  parameter int COORD_BITS = tc_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = tc_pkg::FRAC_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  // first_x, first_y, second_x, second_y, third_x, third_y
  input  logic [((6 * COORD_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  // center_x, center_y
  output logic [2 * tc_pkg::OUT_BITS - 1:0]          out_tdata,
  // collinear, overflow
  output logic [1:0]                                 out_tuser
);

  localparam int NW   = 3 * COORD_BITS + 5;
  localparam int DTW  = 2 * COORD_BITS + 3;
  localparam int FLW  = $bits(tc_pkg::flags_t);
  localparam int FW   = 2 * NW + DTW + FLW;
  localparam int QD   = tc_pkg::QUEUE_DEPTH;
  localparam int CRW  = $clog2(QD) + 1;
  localparam int OUTW = tc_pkg::OUT_BITS;

  logic                 in_acc;
  logic [CRW-1:0]       credit_r, credit_nxt;
  logic                 fr_valid;
  logic [NW-1:0]        fr_mag_x, fr_mag_y, q_mag_x, q_mag_y;
  logic [DTW-1:0]       fr_mag_det, q_mag_det;
  tc_pkg::flags_t       fr_flags, q_flags;
  logic [FW-1:0]        q_head;
  logic                 q_empty, q_pop, div_ready;
  logic [CRW-1:0]       q_count;
  logic [OUTW-1:0]      cx, cy;
  logic                 col, ovf;

  assign in_acc = in_tvalid && in_tready;

  // Count words in the front and the queue; take a new one only if it fits
  always_comb begin
    credit_nxt = credit_r + CRW'(in_acc) - CRW'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_nxt;
    end
  end

  assign in_tready = (credit_r < CRW'(QD));

  tc_front #(
    .COORD_BITS (COORD_BITS),
    .NW         (NW),
    .DTW        (DTW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_acc),
    .x0        (in_tdata[0 * COORD_BITS +: COORD_BITS]),
    .y0        (in_tdata[1 * COORD_BITS +: COORD_BITS]),
    .x1        (in_tdata[2 * COORD_BITS +: COORD_BITS]),
    .y1        (in_tdata[3 * COORD_BITS +: COORD_BITS]),
    .x2        (in_tdata[4 * COORD_BITS +: COORD_BITS]),
    .y2        (in_tdata[5 * COORD_BITS +: COORD_BITS]),
    .out_valid (fr_valid),
    .mag_x     (fr_mag_x),
    .mag_y     (fr_mag_y),
    .mag_det   (fr_mag_det),
    .flags     (fr_flags)
  );

  tc_fifo #(
    .WIDTH (FW),
    .DEPTH (QD)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fr_valid),
    .push_data ({fr_flags, fr_mag_det, fr_mag_y, fr_mag_x}),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .count     (q_count)
  );

  assign {q_flags, q_mag_det, q_mag_y, q_mag_x} = q_head;
  assign q_pop = div_ready && !q_empty;

  tc_div #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .NW         (NW),
    .DTW        (DTW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (!q_empty),
    .in_ready  (div_ready),
    .mag_x     (q_mag_x),
    .mag_y     (q_mag_y),
    .mag_det   (q_mag_det),
    .flags     (q_flags),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .center_x  (cx),
    .center_y  (cy),
    .collinear (col),
    .overflow  (ovf)
  );

  assign out_tdata = {cy, cx};
  assign out_tuser = {ovf, col};

  // Credit never exceeds the queue depth
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= CRW'(QD))
    else $error("credit above queue depth");

  // Queued words are a subset of the counted ones
  a_queue_in_credit: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= credit_r)
    else $error("queue holds uncounted words");

  // The front never pushes into a full queue
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (q_count == CRW'(QD)) |-> !fr_valid)
    else $error("queue overrun");

  // Collinear results carry zero coordinates and no overflow
  a_collinear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == '0 && !out_tuser[1]))
    else $error("collinear result not cleared");

endmodule

[verif/triangle_circumcenter_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_circumcenter_tb: self-checking bench for the circumcenter block
// Drives directed triangles, then random ones in bursts with random gaps. A
// scoreboard computes each expected center exactly with wide integers and
// compares the out_ stream words, in order. The receiver stalls at random.
// ----------------------------------------------------------------------------
class center_scoreboard;
  localparam int OB = tc_pkg::OUT_BITS;
  typedef struct {
    logic [OB-1:0] cx;
    logic [OB-1:0] cy;
    logic          colin;
    logic          ovf;
  } center_t;

  center_t pending[$];
  int      mismatches;

  // Round num * 2^8 / (2*den), ties away from zero, and saturate to OB bits
  function logic [OB-1:0] round_div(logic signed [127:0] num,
                                    logic signed [63:0] den, ref logic sat);
    logic          neg;
    logic [127:0]  n;
    logic [127:0]  d;
    logic [127:0]  q;
    logic [127:0]  lim;
    neg = num[127] != den[63];
    n = num[127] ? -num : num;
    d = den[63] ? -{{64{den[63]}}, den} : {64'd0, den};
    q = ((n << 9) + (d << 1)) / (d << 2);
    lim = neg ? (128'd1 << (OB - 1)) : ((128'd1 << (OB - 1)) - 1);
    if (q > lim) begin
      sat = 1'b1;
      q = lim;
    end
    return neg ? -q[OB-1:0] : q[OB-1:0];
  endfunction

  // Note one accepted triangle and queue its expected center
  function void note_triangle(logic [95:0] w);
    logic signed [63:0]  x0, y0, x1, y1, x2, y2, a, b, det;
    logic signed [127:0] nx, ny;
    logic                sat;
    center_t             e;
    x0 = $signed(w[15:0]);  y0 = $signed(w[31:16]);
    x1 = $signed(w[47:32]); y1 = $signed(w[63:48]);
    x2 = $signed(w[79:64]); y2 = $signed(w[95:80]);
    a = x0*x0 - x1*x1 + y0*y0 - y1*y1;
    b = x0*x0 - x2*x2 + y0*y0 - y2*y2;
    det = (x0 - x1) * (y0 - y2) - (x0 - x2) * (y0 - y1);
    sat = 1'b0;
    if (det == 0) begin
      e = '{cx: '0, cy: '0, colin: 1'b1, ovf: 1'b0};
    end else begin
      nx = 128'(a) * 128'(y0 - y2) - 128'(b) * 128'(y0 - y1);
      ny = 128'(a) * 128'(x0 - x2) - 128'(b) * 128'(x0 - x1);
      e.cx = round_div(nx, det, sat);
      e.cy = round_div(-ny, det, sat);
      e.colin = 1'b0;
      e.ovf = sat;
    end
    pending.push_back(e);
  endfunction

  // Compare one output word against the oldest expected center
  function void check_center(logic [2*OB-1:0] data, logic [1:0] user);
    center_t e;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected output word %h %b", data, user);
      return;
    end
    e = pending.pop_front();
    if (data[OB-1:0] !== e.cx || data[2*OB-1:OB] !== e.cy ||
        user[0] !== e.colin || user[1] !== e.ovf) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp x=%h y=%h col=%b ovf=%b got x=%h y=%h col=%b ovf=%b",
                 e.cx, e.cy, e.colin, e.ovf, data[OB-1:0], data[2*OB-1:OB],
                 user[0], user[1]);
    end
  endfunction
endclass

module triangle_circumcenter_tb;
  localparam int LATENCY = 3 * 16 + 8 + 13;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [95:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [95:0]  out_tdata;
  logic [1:0]   out_tuser;

  center_scoreboard sb = new();
  bit           stall_mode;

  triangle_circumcenter dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #5 clk = ~clk;

  // Sample both handshakes at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_triangle(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_center(out_tdata, out_tuser);
  end

  // Receiver stall pattern: phases of rare stalls and of heavy stalling
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode = ~stall_mode;
    if (stall_mode) out_tready <= ($urandom_range(0, 3) != 0);
    else            out_tready <= ($urandom_range(0, 40) != 0);
  end

  // Present one triangle and hold it until accepted
  task automatic send_triangle(logic [95:0] w);
    in_tdata  <= w;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drop_valid();
    in_tvalid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($signed($urandom_range(0, 40)) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [95:0] rand_triangle();
    logic [95:0] w;
    for (int i = 0; i < 6; i++) w[i*16 +: 16] = rand_coord();
    // Collinear points, repeated points and tiny, nearly flat triangles
    case ($urandom_range(0, 9))
      0: w[47:32] = w[15:0];
      1: w[95:64] = w[31:0];
      2: begin
        w[47:32] = 16'($signed(w[15:0]) + 1);   w[63:48] = 16'($signed(w[31:16]) + 2);
        w[79:64] = 16'($signed(w[15:0]) + 2);   w[95:80] = 16'($signed(w[31:16]) + 4);
      end
      3: begin
        w[47:32] = 16'($signed(w[15:0]) + 1);   w[63:48] = 16'($signed(w[31:16]) + 2);
        w[79:64] = 16'($signed(w[15:0]) + 2);   w[95:80] = 16'($signed(w[31:16]) + 5);
      end
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    stall_mode = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, collinear, repeated, exact ties, saturation
    send_triangle({16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
    send_triangle({16'd0, 16'd2, 16'd0, 16'd0, 16'd2, 16'd0});
    send_triangle({16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd1});
    send_triangle({16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF});
    send_triangle({16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000});
    send_triangle({16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000});
    send_triangle({16'd2, 16'd2, 16'd1, 16'd1, 16'd0, 16'd0});
    send_triangle({16'd5, 16'd3, 16'd5, 16'd3, 16'd1, 16'd7});
    send_triangle({16'd2, 16'h7FFF, 16'd1, 16'h8000, 16'd0, 16'h8000});
    send_triangle({16'd1, 16'h7FFF, 16'd0, 16'h8000, 16'd0, 16'h8001});
    send_triangle({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_triangle({16'd3, 16'd0, 16'd0, 16'd7, 16'd0, 16'd0});
    send_triangle({16'hFFFD, 16'd0, 16'd0, 16'hFFF9, 16'd0, 16'd0});
    send_triangle(96'hAAAA_5555_AAAA_5555_1234_8765);
    drop_valid();

    // Hold off until every expected center has arrived
    while (sb.pending.size() != 0) @(negedge clk);

    // Random bursts with gaps
    for (int n = 0; n < 850; ) begin
      int burst;
      burst = $urandom_range(1, 30);
      for (int k = 0; k < burst && n < 850; k++, n++) send_triangle(rand_triangle());
      if ($urandom_range(0, 3) != 0) begin
        drop_valid();
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
    drop_valid();

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

[triangle_circumcenter.f]
hw/rtl/tc_pkg.sv
hw/rtl/tc_front.sv
hw/rtl/tc_fifo.sv
hw/rtl/tc_div.sv
hw/rtl/triangle_circumcenter.sv
verif/triangle_circumcenter_tb.sv
